@@ hw/rtl/gvm_pkg.sv @@
package gvm_pkg;

    // Default build
    localparam int DEF_SAMPLE_ADDR_BITS = 20;
    localparam int DEF_MAX_VOICES       = 8;
    localparam int DEF_SINE_TABLE_DEPTH = 1024;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SADDR_W  = 20;
    localparam int SAMPLE_W = 16;
    localparam int VIDX_W   = 3;
    localparam int SIZE_W   = 16;
    localparam int POS_W    = 36;
    localparam int SPEED_W  = 16;
    localparam int GAIN_W   = 16;
    localparam int VCNT_W   = 4;
    localparam int ENV_W    = 32;
    localparam int STEP_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int IPART_W  = 20;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Reset values
    localparam logic [GAIN_W-1:0]  GAIN_RESET       = 16'd819;
    localparam logic [VCNT_W-1:0]  VCNT_RESET       = 4'd0;
    localparam logic [SIZE_W-1:0]  PEND_SIZE_RESET  = 16'd1000;
    localparam logic [SPEED_W-1:0] PEND_SPEED_RESET = 16'd4096;

    // Item commands
    typedef enum logic [CMD_W-1:0] {
        CMD_STORE_WRITE = 2'd0,
        CMD_VOICE_SET   = 2'd1,
        CMD_TICK        = 2'd2,
        CMD_UNUSED      = 2'd3
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OUTPUT_GAIN = 1'd0,
        CFG_VOICE_COUNT = 1'd1
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_RD0,
        ST_RD1,
        ST_MUL0,
        ST_MUL1,
        ST_ADV,
        ST_MIX,
        ST_OUT
    } t_state;

    // Store read select
    typedef enum logic [1:0] {
        RD_NONE,
        RD_A0,
        RD_A1
    } t_rd_sel;

    // Controller to datapath
    typedef struct packed {
        logic    store_we;
        logic    pend_we;
        logic    tick_start;
        logic    grain_start;
        t_rd_sel rd_sel;
        logic    interp0;
        logic    interp1;
        logic    window_mul;
        logic    advance;
        logic    mix;
        logic    out_load;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic              restart_due;
        logic              div_busy;
        logic              out_full;
        logic [VCNT_W-1:0] voice_count;
    } t_dp_status;

endpackage

@@ hw/rtl/gvm_if.sv @@
// Input item channel
interface gvm_in_if;
    import gvm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           cmd;
    logic [SADDR_W-1:0]         sample_address;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic [VIDX_W-1:0]          voice_index;
    logic [SIZE_W-1:0]          grain_size;
    logic [POS_W-1:0]           start_location;
    logic [SPEED_W-1:0]         playback_speed;

    modport source(output valid, cmd, sample_address, sample_value, voice_index,
                   grain_size, start_location, playback_speed, input ready);
    modport sink(input valid, cmd, sample_address, sample_value, voice_index,
                 grain_size, start_location, playback_speed, output ready);
endinterface

// Result channel
interface gvm_out_if;
    import gvm_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] mixed_sample;
    logic                       clipped;

    modport source(output valid, mixed_sample, clipped, input ready);
    modport sink(input valid, mixed_sample, clipped, output ready);
endinterface

@@ hw/rtl/gvm_div.sv @@
// Restoring divider, one quotient bit per cycle
module gvm_div #(
    parameter int NUM_W = 47,
    parameter int DEN_W = 28,
    parameter int Q_W   = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_busy,
    output logic             o_done,
    output logic [Q_W-1:0]   o_quot
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] r_q, n_q;
    logic [DEN_W-1:0] r_rem, n_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic             take;

    // One trial subtract per cycle
    always_comb begin
        rem_sh = {r_rem, r_q[NUM_W-1]};
        take   = (rem_sh >= {1'b0, r_den});
        n_rem  = take ? DEN_W'(rem_sh - {1'b0, r_den}) : DEN_W'(rem_sh);
        n_q    = {r_q[NUM_W-2:0], take};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and partial result registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_q   <= n_q;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q[Q_W-1:0];
endmodule

@@ hw/rtl/gvm_ctrl.sv @@
// Sequencer: decodes items and walks the voices on a tick
module gvm_ctrl #(
    parameter int MAX_VOICES = gvm_pkg::DEF_MAX_VOICES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic [gvm_pkg::CMD_W-1:0] i_in_cmd,
    output logic                     o_in_ready,
    input  gvm_pkg::t_dp_status      i_status,
    output gvm_pkg::t_dp_cmd         o_cmd,
    output logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] o_voice
);
    import gvm_pkg::*;

    localparam int VW  = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int VCW = $clog2(MAX_VOICES + 1);

    t_state         r_state, n_state;
    logic [VCW-1:0] r_voice, n_voice;
    logic [VCW-1:0] r_count, n_count;
    logic [VCW-1:0] eff_count;
    logic           in_xfer;
    t_cmd           cmd;

    assign cmd       = t_cmd'(i_in_cmd);
    assign in_xfer   = i_in_valid && o_in_ready;
    assign eff_count = (32'(i_status.voice_count) > MAX_VOICES) ? VCW'(MAX_VOICES)
                                                                 : VCW'(i_status.voice_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_voice <= '0;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_voice <= n_voice;
            r_count <= n_count;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_voice    = r_voice;
        n_count    = r_count;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (in_xfer) begin
                    case (cmd)
                        CMD_STORE_WRITE: o_cmd.store_we = 1'b1;
                        CMD_VOICE_SET:   o_cmd.pend_we  = 1'b1;
                        CMD_TICK: begin
                            o_cmd.tick_start = 1'b1;
                            n_voice = '0;
                            n_count = eff_count;
                            n_state = (eff_count == '0) ? ST_MIX : ST_LOAD;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOAD: begin
                if (i_status.restart_due) begin
                    o_cmd.grain_start = 1'b1;
                    n_state = ST_DIV;
                end else begin
                    n_state = ST_RD0;
                end
            end
            ST_DIV: begin
                if (!i_status.div_busy) n_state = ST_RD0;
            end
            ST_RD0: begin
                o_cmd.rd_sel = RD_A0;
                n_state = ST_RD1;
            end
            ST_RD1: begin
                o_cmd.rd_sel  = RD_A1;
                o_cmd.interp0 = 1'b1;
                n_state = ST_MUL0;
            end
            ST_MUL0: begin
                o_cmd.interp1 = 1'b1;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.window_mul = 1'b1;
                n_state = ST_ADV;
            end
            ST_ADV: begin
                o_cmd.advance = 1'b1;
                n_voice = r_voice + 1'b1;
                n_state = (r_voice + 1'b1 == r_count) ? ST_MIX : ST_LOAD;
            end
            ST_MIX: begin
                o_cmd.mix = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                // wait for the result register to drain
                if (!i_status.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_voice = r_voice[VW-1:0];
endmodule

@@ hw/rtl/gvm_dp.sv @@
// Datapath: sample store, voice state, window and mix arithmetic
module gvm_dp #(
    parameter int SAMPLE_ADDR_BITS = gvm_pkg::DEF_SAMPLE_ADDR_BITS,
    parameter int MAX_VOICES       = gvm_pkg::DEF_MAX_VOICES,
    parameter int SINE_TABLE_DEPTH = gvm_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  gvm_pkg::t_dp_cmd                    i_cmd,
    input  logic [((MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1)-1:0] i_voice,
    output gvm_pkg::t_dp_status                 o_status,
    input  logic                                i_cfg_we,
    input  logic [gvm_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [gvm_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic [gvm_pkg::SADDR_W-1:0]         i_sample_address,
    input  logic signed [gvm_pkg::SAMPLE_W-1:0] i_sample_value,
    input  logic [gvm_pkg::VIDX_W-1:0]          i_voice_index,
    input  logic [gvm_pkg::SIZE_W-1:0]          i_grain_size,
    input  logic [gvm_pkg::POS_W-1:0]           i_start_location,
    input  logic [gvm_pkg::SPEED_W-1:0]         i_playback_speed,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [gvm_pkg::SAMPLE_W-1:0] o_mixed_sample,
    output logic                                o_clipped
);
    import gvm_pkg::*;

    localparam int VW       = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
    localparam int AW       = SAMPLE_ADDR_BITS;
    localparam int KW       = $clog2(SINE_TABLE_DEPTH);
    localparam int SIN_W    = 17;
    localparam int VAL_W    = 34;
    localparam int PROD_W   = VAL_W + SIN_W;
    localparam int CON_W    = 34;
    localparam int SUM_W    = CON_W + VW + 1;
    localparam int MIX_W    = SUM_W + GAIN_W + 1;
    localparam int DEN_W    = SIZE_W + 12;
    localparam int NUM_W    = SPEED_W + 31;
    localparam int QUAD_DEN = 4 * SINE_TABLE_DEPTH;
    localparam int HALF_DEN = 2 * SINE_TABLE_DEPTH;
    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    // sin(2*pi*k/depth) in Q1.15, odd series to x^11 on the quarter-wave angle
    function automatic logic signed [SIN_W-1:0] sine_q15(input int unsigned k);
        logic [63:0] r, quad, rem, x, x2, t, s;
        r    = 64'(k) * 64'd4;
        quad = r / SINE_TABLE_DEPTH;
        rem  = r - quad * SINE_TABLE_DEPTH;
        if (quad[0]) rem = SINE_TABLE_DEPTH - rem;
        x  = (rem * TWO_PI_Q30 + HALF_DEN) / QUAD_DEN;
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((x2 * t) >> 30) / 110;
        t  = Q30_ONE - ((x2 * t) >> 30) / 72;
        t  = Q30_ONE - ((x2 * t) >> 30) / 42;
        t  = Q30_ONE - ((x2 * t) >> 30) / 20;
        t  = Q30_ONE - ((x2 * t) >> 30) / 6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        return (quad >= 64'd2) ? -SIN_W'(s) : SIN_W'(s);
    endfunction

    // Window ROM, built at elaboration
    logic signed [SIN_W-1:0] sine_rom [SINE_TABLE_DEPTH];
    for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_rom
        localparam logic signed [SIN_W-1:0] ENTRY = sine_q15(g);
        assign sine_rom[g] = ENTRY;
    end

    // Configuration registers
    logic [GAIN_W-1:0] r_gain;
    logic [VCNT_W-1:0] r_vcount;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_RESET;
            r_vcount <= VCNT_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_OUTPUT_GAIN: r_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_VOICE_COUNT: r_vcount <= i_cfg_data[VCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sample store, one write or one registered read per cycle
    logic signed [SAMPLE_W-1:0] sample_store [2**AW];
    logic signed [SAMPLE_W-1:0] r_rdata;
    logic [AW-1:0]              rd_addr;
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_we) sample_store[AW'(i_sample_address)] <= i_sample_value;
        if (i_cmd.rd_sel != RD_NONE) r_rdata <= sample_store[rd_addr];
    end

    // Voice state
    logic [POS_W-1:0]   r_pos    [MAX_VOICES];
    logic [POS_W-1:0]   r_origin [MAX_VOICES];
    logic [SIZE_W-1:0]  r_size   [MAX_VOICES];
    logic [SPEED_W-1:0] r_speed  [MAX_VOICES];
    logic [ENV_W-1:0]   r_env    [MAX_VOICES];
    logic [STEP_W-1:0]  r_step   [MAX_VOICES];
    logic [SIZE_W-1:0]  r_psize  [MAX_VOICES];
    logic [POS_W-1:0]   r_pstart [MAX_VOICES];
    logic [SPEED_W-1:0] r_pspeed [MAX_VOICES];
    logic [MAX_VOICES-1:0] r_restart;
    logic [VW-1:0]      r_div_voice;

    logic [POS_W-1:0]   pos, new_pos;
    logic [IPART_W-1:0] ipart, ipart1;
    logic [FRAC_W-1:0]  frac;
    logic               live;
    logic               pend_live;
    logic [DEN_W-1:0]   pend_den;
    logic               div_busy, div_done;
    logic [STEP_W-1:0]  div_quot;
    logic               pend_ok;

    assign pos       = r_pos[i_voice];
    assign ipart     = pos[POS_W-1:FRAC_W];
    assign ipart1    = ipart + 1'b1;
    assign frac      = pos[FRAC_W-1:0];
    assign rd_addr   = (i_cmd.rd_sel == RD_A1) ? AW'(ipart1) : AW'(ipart);
    assign live      = {r_size[i_voice], 12'd0} > DEN_W'(r_speed[i_voice]);
    assign pend_live = {r_psize[i_voice], 12'd0} > DEN_W'(r_pspeed[i_voice]);
    assign pend_den  = {r_psize[i_voice], 12'd0} - DEN_W'(r_pspeed[i_voice]);
    assign new_pos   = pos + POS_W'({r_speed[i_voice], 4'd0});
    assign pend_ok   = 32'(i_voice_index) < MAX_VOICES;

    gvm_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(STEP_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.grain_start && pend_live),
        .i_num   ({r_pspeed[i_voice], 31'd0}),
        .i_den   (pend_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // Per-voice state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < MAX_VOICES; v++) begin
                r_pos[v]    <= '0;
                r_origin[v] <= '0;
                r_size[v]   <= '0;
                r_speed[v]  <= '0;
                r_env[v]    <= '0;
                r_step[v]   <= '0;
                r_psize[v]  <= PEND_SIZE_RESET;
                r_pstart[v] <= '0;
                r_pspeed[v] <= PEND_SPEED_RESET;
            end
            r_restart   <= '1;
            r_div_voice <= '0;
        end else begin
            if (i_cmd.pend_we && pend_ok) begin
                r_psize[VW'(i_voice_index)]  <= i_grain_size;
                r_pstart[VW'(i_voice_index)] <= i_start_location;
                r_pspeed[VW'(i_voice_index)] <= i_playback_speed;
            end
            if (i_cmd.grain_start) begin
                r_size[i_voice]    <= r_psize[i_voice];
                r_speed[i_voice]   <= r_pspeed[i_voice];
                r_pos[i_voice]     <= r_pstart[i_voice];
                r_origin[i_voice]  <= r_pstart[i_voice];
                r_env[i_voice]     <= '0;
                r_step[i_voice]    <= '0;
                r_restart[i_voice] <= 1'b0;
                r_div_voice        <= i_voice;
            end
            if (div_done) r_step[r_div_voice] <= div_quot;
            if (i_cmd.advance) begin
                r_pos[i_voice] <= new_pos;
                r_env[i_voice] <= r_env[i_voice] + 1'b1;
                if (new_pos - r_origin[i_voice] >= {r_size[i_voice], 16'd0})
                    r_restart[i_voice] <= 1'b1;
            end
        end
    end

    // Interpolation, window and accumulation
    logic [ENV_W-1:0]         r_phase;
    logic signed [SIN_W-1:0]  r_sin;
    logic signed [VAL_W-1:0]  r_val;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [MIX_W-1:0]  r_mix;
    logic signed [PROD_W-1:0] prod_sh;
    logic signed [17:0]       w0, w1;

    assign w0      = $signed({1'b0, 17'd65536 - 17'(frac)});
    assign w1      = $signed({2'b00, frac});
    assign prod_sh = r_prod >>> 15;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_sel == RD_A0) r_phase <= r_env[i_voice] * r_step[i_voice];
        if (i_cmd.interp0) begin
            r_val <= VAL_W'(r_rdata * w0);
            r_sin <= sine_rom[r_phase[ENV_W-1 -: KW]];
        end
        if (i_cmd.interp1)    r_val  <= r_val + VAL_W'(r_rdata * w1);
        if (i_cmd.window_mul) r_prod <= PROD_W'(r_val * r_sin);
        if (i_cmd.tick_start) begin
            r_sum <= '0;
        end else if (i_cmd.advance && live) begin
            r_sum <= r_sum + SUM_W'(CON_W'(prod_sh));
        end
        if (i_cmd.mix)
            r_mix <= MIX_W'(r_sum * $signed({1'b0, r_gain})) + (MIX_W'(1) <<< 27);
    end

    // Round, saturate and hold the result
    logic signed [MIX_W-1:0] y;
    logic                    sat_hi, sat_lo;
    logic                    r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_sample;
    logic                    r_out_clip;

    assign y      = r_mix >>> 28;
    assign sat_hi = y > MIX_W'(32767);
    assign sat_lo = y < -MIX_W'(32768);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_sample <= sat_hi ? 16'sh7fff : (sat_lo ? 16'sh8000 : SAMPLE_W'(y));
            r_out_clip   <= sat_hi || sat_lo;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_mixed_sample = r_out_sample;
    assign o_clipped      = r_out_clip;

    assign o_status.restart_due = r_restart[i_voice];
    assign o_status.div_busy    = div_busy || div_done;
    assign o_status.out_full    = r_out_valid && !i_out_ready;
    assign o_status.voice_count = r_vcount;
endmodule

@@ hw/rtl/granular_voice_mixer.sv @@
// Store writes and voice settings are done in the idle state. A tick walks the N active
// voices in turn; a voice whose grain restarts on that tick also passes the divide state,
// and waits there for the serial window-step divider when the new grain has a live window.
// The shared store read port (two reads per voice) and the divider set the tick length; one
// item is in work at a time. A tick whose result finds the previous one still waiting holds
// in ST_OUT until that one is taken; other items are not held by a waiting result.
// Reset is synchronous, active low: voice state and registers take their defaults.
// The sample store is not cleared; entries are valid only once written.
module granular_voice_mixer #(
    parameter int SAMPLE_ADDR_BITS = gvm_pkg::DEF_SAMPLE_ADDR_BITS,
    parameter int MAX_VOICES       = gvm_pkg::DEF_MAX_VOICES,
    parameter int SINE_TABLE_DEPTH = gvm_pkg::DEF_SINE_TABLE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    gvm_in_if.sink                         i_in,
    gvm_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [gvm_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [gvm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import gvm_pkg::*;

    localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic [VW-1:0] voice;

    gvm_ctrl #(.MAX_VOICES(MAX_VOICES)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_cmd   (i_in.cmd),
        .o_in_ready (i_in.ready),
        .i_status   (dp_status),
        .o_cmd      (dp_cmd),
        .o_voice    (voice)
    );

    gvm_dp #(
        .SAMPLE_ADDR_BITS (SAMPLE_ADDR_BITS),
        .MAX_VOICES       (MAX_VOICES),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_voice          (voice),
        .o_status         (dp_status),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_sample_address (i_in.sample_address),
        .i_sample_value   (i_in.sample_value),
        .i_voice_index    (i_in.voice_index),
        .i_grain_size     (i_in.grain_size),
        .i_start_location (i_in.start_location),
        .i_playback_speed (i_in.playback_speed),
        .i_out_ready      (o_out.ready),
        .o_out_valid      (o_out.valid),
        .o_mixed_sample   (o_out.mixed_sample),
        .o_clipped        (o_out.clipped)
    );
endmodule

@@ hw/rtl/gvm_checker.sv @@
// Port-level checks on the mixer
module gvm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                i_in_ready,
    input logic [gvm_pkg::CMD_W-1:0]           i_in_cmd,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic signed [gvm_pkg::SAMPLE_W-1:0] i_mixed_sample,
    input logic                                i_clipped
);
    import gvm_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_mixed_sample)
                                         && $stable(i_clipped))
        else $error("result changed while stalled");

    // No result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // Only ticks produce results
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd != CMD_TICK) && !i_out_valid
        |=> !i_out_valid)
        else $error("result from a non-tick item");

    // A tick occupies the block
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_cmd == CMD_TICK) |=> !i_in_ready)
        else $error("input taken during a tick");

    // Clip flag only at the rails
    a_clip_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_clipped |-> (i_mixed_sample == 16'sh7fff)
                                     || (i_mixed_sample == 16'sh8000))
        else $error("clip flag off the rails");
endmodule

bind granular_voice_mixer gvm_checker u_gvm_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_in_cmd       (i_in.cmd),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_mixed_sample (o_out.mixed_sample),
    .i_clipped      (o_out.clipped)
);

@@ tb/sv/granular_voice_mixer_checker.sv @@
// Watches the item, result and register channels, predicts each tick's mix
// and compares every result transfer with the oldest prediction.
module granular_voice_mixer_checker
    import gvm_pkg::*;
#(
    parameter int SAMPLE_ADDR_BITS = DEF_SAMPLE_ADDR_BITS,
    parameter int MAX_VOICES       = DEF_MAX_VOICES,
    parameter int SINE_TABLE_DEPTH = DEF_SINE_TABLE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gvm_in_if                     in_ch,
    gvm_out_if                    out_ch,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint unsigned POS_MASK   = (64'd1 << POS_W) - 1;
    localparam longint unsigned ADDR_MASK  = (64'd1 << SAMPLE_ADDR_BITS) - 1;
    localparam longint unsigned Q30_ONE    = 64'd1 << 30;
    localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clip;
    } t_mix_result;

    // Predicted state
    logic signed [SAMPLE_W-1:0] sample_mem [longint unsigned];
    logic [POS_W-1:0]   rd_pos     [MAX_VOICES];
    logic [POS_W-1:0]   origin     [MAX_VOICES];
    logic [SIZE_W-1:0]  act_size   [MAX_VOICES];
    logic [SPEED_W-1:0] act_speed  [MAX_VOICES];
    logic [ENV_W-1:0]   env_cnt    [MAX_VOICES];
    logic [STEP_W-1:0]  win_step   [MAX_VOICES];
    logic [SIZE_W-1:0]  pend_size  [MAX_VOICES];
    logic [POS_W-1:0]   pend_start [MAX_VOICES];
    logic [SPEED_W-1:0] pend_speed [MAX_VOICES];
    logic               restart    [MAX_VOICES];
    logic [GAIN_W-1:0]  gain;
    logic [VCNT_W-1:0]  vcount;

    t_mix_result mix_queue [$];
    int          fails;

    // Half-sine window value in Q1.15 for table index k
    function automatic longint window_q15(longint unsigned k);
        longint unsigned dens [5] = '{110, 72, 42, 20, 6};
        longint unsigned d, r, quad, rem, x, x2, t, s;
        d    = SINE_TABLE_DEPTH;
        r    = k * 4;
        quad = r / d;
        rem  = r - quad * d;
        if (quad[0]) begin
            rem = d - rem;
        end
        x  = (rem * TWO_PI_Q30 + 2 * d) / (4 * d);
        x2 = (x * x) >> 30;
        t  = Q30_ONE;
        for (int i = 0; i < 5; i++) begin
            t = Q30_ONE - ((x2 * t) >> 30) / dens[i];
        end
        s = (x * t) >> 30;
        s = (s + (64'd1 << 14)) >> 15;
        return (quad >= 2) ? -longint'(s) : longint'(s);
    endfunction

    function automatic bit grain_live(int v);
        return longint'(act_size[v]) * 4096 > longint'(act_speed[v]);
    endfunction

    function automatic void load_grain(int v);
        longint unsigned den;
        act_size[v]  = pend_size[v];
        act_speed[v] = pend_speed[v];
        rd_pos[v]    = pend_start[v];
        origin[v]    = pend_start[v];
        env_cnt[v]   = '0;
        win_step[v]  = '0;
        if (grain_live(v)) begin
            den         = longint'(act_size[v]) * 4096 - act_speed[v];
            win_step[v] = STEP_W'((longint'(act_speed[v]) << 31) / den);
        end
        restart[v] = 1'b0;
    endfunction

    // One voice's contribution for this tick, then advance it
    function automatic longint voice_contrib(int v);
        longint          c;
        longint          frac;
        longint          val;
        longint unsigned pos, a0, a1, k;
        logic [IPART_W-1:0] ip;
        logic [ENV_W-1:0]   phase;
        c = 0;
        if (restart[v]) begin
            load_grain(v);
        end
        pos  = rd_pos[v];
        ip   = pos[POS_W-1:FRAC_W];
        a0   = ip & ADDR_MASK;
        a1   = IPART_W'(ip + 1) & ADDR_MASK;
        frac = pos[FRAC_W-1:0];
        if (grain_live(v)) begin
            val = longint'(sample_mem[a0]) * (65536 - frac)
                + longint'(sample_mem[a1]) * frac;
            phase = env_cnt[v] * win_step[v];
            k     = (longint'(phase) * SINE_TABLE_DEPTH) >> 32;
            c     = (val * window_q15(k)) >>> 15;
        end
        rd_pos[v]  = POS_W'((pos + (longint'(act_speed[v]) << 4)) & POS_MASK);
        env_cnt[v] = env_cnt[v] + 1;
        if (((longint'(rd_pos[v]) - longint'(origin[v])) & POS_MASK)
                >= (longint'(act_size[v]) << 16)) begin
            restart[v] = 1'b1;
        end
        return c;
    endfunction

    function automatic t_mix_result mix_tick();
        t_mix_result res;
        longint      sum, y;
        int          n;
        sum = 0;
        n   = (vcount > MAX_VOICES) ? MAX_VOICES : vcount;
        for (int v = 0; v < n; v++) begin
            sum += voice_contrib(v);
        end
        y        = (sum * longint'(gain) + (64'sd1 <<< 27)) >>> 28;
        res.clip = 1'b0;
        if (y > 32767) begin
            y        = 32767;
            res.clip = 1'b1;
        end
        if (y < -32768) begin
            y        = -32768;
            res.clip = 1'b1;
        end
        res.sample = SAMPLE_W'(y);
        return res;
    endfunction

    // Predict on each item transfer, compare on each result transfer
    always @(posedge i_clk) begin
        t_mix_result want;
        t_mix_result fresh;
        if (!i_rst_n) begin
            for (int v = 0; v < MAX_VOICES; v++) begin
                rd_pos[v]     = '0;
                origin[v]     = '0;
                act_size[v]   = '0;
                act_speed[v]  = '0;
                env_cnt[v]    = '0;
                win_step[v]   = '0;
                pend_size[v]  = PEND_SIZE_RESET;
                pend_start[v] = '0;
                pend_speed[v] = PEND_SPEED_RESET;
                restart[v]    = 1'b1;
            end
            gain   = GAIN_RESET;
            vcount = VCNT_RESET;
            mix_queue.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_OUTPUT_GAIN: gain = i_cfg_data[GAIN_W-1:0];
                    CFG_VOICE_COUNT: vcount = i_cfg_data[VCNT_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                case (t_cmd'(in_ch.cmd))
                    CMD_STORE_WRITE: begin
                        sample_mem[longint'(in_ch.sample_address) & ADDR_MASK] =
                            in_ch.sample_value;
                    end
                    CMD_VOICE_SET: begin
                        if (in_ch.voice_index < MAX_VOICES) begin
                            pend_size[in_ch.voice_index]  = in_ch.grain_size;
                            pend_start[in_ch.voice_index] = in_ch.start_location;
                            pend_speed[in_ch.voice_index] = in_ch.playback_speed;
                        end
                    end
                    CMD_TICK: begin
                        fresh = mix_tick();
                        mix_queue.insert(mix_queue.size(), fresh);
                    end
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (mix_queue.size() == 0) begin
                    fails++;
                    $display("%0t: result transfer with nothing expected: sample %0d clip %0b",
                             $time, out_ch.mixed_sample, out_ch.clipped);
                end else begin
                    want = mix_queue.pop_front();
                    if (out_ch.mixed_sample !== want.sample) begin
                        fails++;
                        $display("%0t: mixed_sample expected %0d actual %0d",
                                 $time, want.sample, out_ch.mixed_sample);
                    end
                    if (out_ch.clipped !== want.clip) begin
                        fails++;
                        $display("%0t: clipped expected %0b actual %0b",
                                 $time, want.clip, out_ch.clipped);
                    end
                end
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= mix_queue.size();
    end

endmodule

@@ tb/sv/granular_voice_mixer_tb.sv @@
// Stimulus and verdict; prediction lives in the checker.
module granular_voice_mixer_tb;
    import gvm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_LIMIT    = 4000000;
    localparam int SETTLE_WAIT  = 600;
    localparam int PHASE_ITEMS  = 128;
    localparam int NUM_PHASES   = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    outstanding;
    int                    cycles;
    bit                    tx_no_gaps;
    bit                    rx_no_stall;
    bit                    rx_long_hold;

    gvm_in_if  in_ch ();
    gvm_out_if out_ch ();

    granular_voice_mixer dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    granular_voice_mixer_checker mix_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic logic [POS_W-1:0] rand_pos();
        return POS_W'({$urandom, $urandom});
    endfunction

    // Start inside the written store area: just below the top or just above zero
    function automatic logic [POS_W-1:0] safe_start();
        int                 r;
        logic [IPART_W-1:0] ip;
        r  = $urandom_range(0, 127);
        ip = (r < 64) ? IPART_W'(20'hFFFC0 + r) : IPART_W'(r - 64);
        return {ip, FRAC_W'($urandom)};
    endfunction

    function automatic logic [SIZE_W-1:0] safe_size();
        return ($urandom_range(0, 3) == 0) ? SIZE_W'($urandom_range(0, 300))
                                           : SIZE_W'($urandom_range(0, 64));
    endfunction

    function automatic logic [SPEED_W-1:0] rand_speed();
        case ($urandom_range(0, 3))
            0: return SPEED_W'($urandom);
            1: return SPEED_W'($urandom_range(0, 8));
            default: return SPEED_W'($urandom_range(2048, 8192));
        endcase
    endfunction

    // One item transfer with a random lead-in gap, or none when tx_no_gaps is set
    task automatic push_item(t_cmd c, logic [SADDR_W-1:0] a, logic [SAMPLE_W-1:0] sv,
                             logic [VIDX_W-1:0] vi, logic [SIZE_W-1:0] gs,
                             logic [POS_W-1:0] sl, logic [SPEED_W-1:0] sp);
        int gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= c;
        in_ch.sample_address <= a;
        in_ch.sample_value   <= sv;
        in_ch.voice_index    <= vi;
        in_ch.grain_size     <= gs;
        in_ch.start_location <= sl;
        in_ch.playback_speed <= sp;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic store_write(logic [SADDR_W-1:0] a, logic [SAMPLE_W-1:0] sv);
        push_item(CMD_STORE_WRITE, a, sv, VIDX_W'($urandom), SIZE_W'($urandom), rand_pos(),
                  SPEED_W'($urandom));
    endtask

    task automatic voice_set(logic [VIDX_W-1:0] vi, logic [SIZE_W-1:0] gs,
                             logic [POS_W-1:0] sl, logic [SPEED_W-1:0] sp);
        push_item(CMD_VOICE_SET, SADDR_W'($urandom), SAMPLE_W'($urandom), vi, gs, sl, sp);
    endtask

    task automatic tick();
        push_item(CMD_TICK, SADDR_W'($urandom), SAMPLE_W'($urandom), VIDX_W'($urandom),
                  SIZE_W'($urandom), rand_pos(), SPEED_W'($urandom));
    endtask

    task automatic unused_cmd();
        push_item(CMD_UNUSED, SADDR_W'($urandom), SAMPLE_W'($urandom), VIDX_W'($urandom),
                  SIZE_W'($urandom), rand_pos(), SPEED_W'($urandom));
    endtask

    // Full-range settings, overwritten by safe ones before any tick consumes them
    task automatic noisy_voice_pair();
        logic [VIDX_W-1:0] vi;
        vi = VIDX_W'($urandom);
        voice_set(vi, SIZE_W'($urandom), rand_pos(), SPEED_W'($urandom));
        voice_set(vi, safe_size(), safe_start(), rand_speed());
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every predicted result, then let a restart-heavy tick finish
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    // Result side: random stalls, one long hold-off when asked
    initial begin
        int stall;
        bit held;
        held = 1'b0;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (rx_long_hold && !held) begin
                out_ch.ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                held = 1'b1;
            end
            stall = rx_no_stall ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    // Item side
    initial begin
        logic [CFG_DATA_W-1:0] gain_set [NUM_PHASES];
        logic [CFG_DATA_W-1:0] count_set [NUM_PHASES];
        int                    r;
        gain_set  = '{16'd0, 16'd4096, 16'd65535, 16'd819, 16'd40960, 16'd4096, 16'd2000,
                      16'd12000};
        count_set = '{16'd1, 16'd8, 16'd0, 16'd3, 16'd15, 16'd8, 16'd5, 16'd12};
        i_rst_n              <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_idx              <= CFG_OUTPUT_GAIN;
        cfg_data             <= '0;
        in_ch.valid          <= 1'b0;
        in_ch.cmd            <= CMD_UNUSED;
        in_ch.sample_address <= '0;
        in_ch.sample_value   <= '0;
        in_ch.voice_index    <= '0;
        in_ch.grain_size     <= '0;
        in_ch.start_location <= '0;
        in_ch.playback_speed <= '0;
        tx_no_gaps   = 1'b0;
        rx_no_stall  = 1'b0;
        rx_long_hold = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero voices after reset, and an ignored command
        tick();
        unused_cmd();

        // Fill the store area that grains may read
        for (int a = 0; a < 384; a++) begin
            store_write(SADDR_W'(a), SAMPLE_W'($urandom));
        end
        for (int a = 0; a < 64; a++) begin
            store_write(SADDR_W'(20'hFFFC0 + a), SAMPLE_W'($urandom));
        end
        store_write(20'h00000, 16'h7FFF);
        store_write(20'h00001, 16'h8000);
        store_write(20'hFFFFF, 16'h7FFF);
        drain();

        // Directed grains at ten times unity gain and an oversized voice count
        cfg_write(CFG_OUTPUT_GAIN, 16'd40960);
        cfg_write(CFG_VOICE_COUNT, 16'd15);
        voice_set(0, 16'd64, 36'h0_0003_2000, 16'd2048);
        voice_set(1, 16'd0, 36'h0_0000_0000, 16'd0);        // size and speed both zero
        voice_set(2, 16'd1, 36'h0_0001_8000, 16'd4096);     // size equals speed
        voice_set(3, 16'd8, 36'hF_FFFF_FFFF, 16'd65535);    // read across the address wrap
        voice_set(4, 16'd5, 36'h0_0002_0000, 16'd0);        // stalled read position
        voice_set(5, 16'd300, 36'h0_0000_0000, 16'd4096);
        voice_set(6, 16'd300, 36'h0_0000_0000, 16'd8192);
        noisy_voice_pair();
        voice_set(7, 16'd2, 36'hF_FFC0_4000, 16'd1);
        repeat (6) tick();
        unused_cmd();
        drain();

        // Random phases
        for (int p = 0; p < NUM_PHASES; p++) begin
            cfg_write(CFG_OUTPUT_GAIN, (p == 6) ? CFG_DATA_W'($urandom) : gain_set[p]);
            cfg_write(CFG_VOICE_COUNT, (p == 7) ? CFG_DATA_W'($urandom_range(0, 15))
                                                : count_set[p]);
            tx_no_gaps  = (p == 2) || (p == 5);
            rx_no_stall = (p == 2);
            if (p == 3) begin
                rx_long_hold = 1'b1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    tick();
                end else if (r < 70) begin
                    voice_set(VIDX_W'($urandom), safe_size(), safe_start(), rand_speed());
                end else if (r < 76) begin
                    store_write(SADDR_W'($urandom_range(0, 383)), SAMPLE_W'($urandom));
                end else if (r < 82) begin
                    store_write(SADDR_W'($urandom), SAMPLE_W'($urandom));
                end else if (r < 94) begin
                    noisy_voice_pair();
                end else begin
                    unused_cmd();
                end
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/gvm_pkg.sv
hw/rtl/gvm_if.sv
hw/rtl/gvm_div.sv
hw/rtl/gvm_ctrl.sv
hw/rtl/gvm_dp.sv
hw/rtl/granular_voice_mixer.sv
hw/rtl/gvm_checker.sv
tb/sv/granular_voice_mixer_checker.sv
tb/sv/granular_voice_mixer_tb.sv
